// File: sv/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_BACK  = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_MOVE  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   localparam int CELL_W = 16;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CALC   = 7'b0000010,
      ST_ADDR   = 7'b0000100,
      ST_ACCESS = 7'b0001000,
      ST_CLEAR  = 7'b0010000,
      ST_LIN    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// File: sv/text_console_writer_top.sv
`default_nettype none
// Text console: ROWS x COLS cell store (char low byte, attribute high byte) plus cursor.
// A command steps from the start transfer through CALC, ADDR, ACCESS and LIN to the
// DONE result strobe; clear replaces ACCESS by CLEAR, which writes all ROWS*COLS cells
// through the single RAM port. One command at a time, sequenced around the one shared
// row*COLS+col unit, used once for the RAM address and once for the linear cursor.
// Reset (synchronous, active high): cursor at origin, not blocked, color 0; cells undefined.
// The receiver cannot stall: rsp_valid is a single-cycle strobe.
module text_console_writer_top #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // command channel
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_operation,
   input  wire logic [7:0] req_char_code,
   input  wire logic [4:0] req_target_row,
   input  wire logic [6:0] req_target_col,
   // result channel
   output logic            rsp_valid,
   output logic [4:0]      rsp_cursor_row,
   output logic [6:0]      rsp_cursor_col,
   output logic [10:0]     rsp_cursor_linear,
   output logic [7:0]      rsp_cell_char,
   output logic [7:0]      rsp_cell_attr,
   output logic            rsp_writes_blocked,
   // text color register
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   localparam int NCELLS = ROWS * COLS;
   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int AW     = $clog2(NCELLS);

   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
   localparam logic [AW-1:0] LAST_ADR = AW'(NCELLS - 1);

   // sequencer and latched command
   tcw_pkg::state_type state_ff, state_in;
   logic [2:0]    op_ff,   op_in;
   logic [7:0]    ch_ff,   ch_in;
   logic [4:0]    trow_ff, trow_in;
   logic [6:0]    tcol_ff, tcol_in;

   // architectural state
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          blk_ff, blk_in;
   logic [7:0]    color_ff, color_in;

   // work registers
   logic          we_ff,    we_in;      // command writes one cell
   logic          rd_ff,    rd_in;      // command reads one cell
   logic          clr_ff,   clr_in;     // command sweeps the store
   logic [7:0]    wchar_ff, wchar_in;
   logic [RW-1:0] arow_ff,  arow_in;
   logic [CW-1:0] acol_ff,  acol_in;
   logic [AW-1:0] addr_ff,  addr_in;
   logic [AW-1:0] lin_ff,   lin_in;
   logic [7:0]    cchar_ff, cchar_in;
   logic [7:0]    cattr_ff, cattr_in;

   // shared address unit: row*COLS + col
   logic [RW-1:0] mul_row;
   logic [CW-1:0] mul_col;
   logic [AW-1:0] mul_res;

   // RAM port
   logic          ram_we;
   logic [15:0]   ram_wdata;
   logic [15:0]   ram_rdata;

   // command decode from current cursor state
   logic          in_range;
   logic          at_last_row;
   logic          at_last_col;
   logic [RW-1:0] row_c;
   logic [CW-1:0] col_c;
   logic          blk_c, we_c, rd_c, clr_c;
   logic [RW-1:0] arow_c;
   logic [CW-1:0] acol_c;
   logic [7:0]    wchar_c;

   assign busy = (state_ff != tcw_pkg::ST_IDLE);

   assign in_range    = (32'(trow_ff) < ROWS) && (32'(tcol_ff) < COLS);
   assign at_last_row = (row_ff == LAST_ROW);
   assign at_last_col = (col_ff == LAST_COL);

   always_comb begin
      row_c   = row_ff;
      col_c   = col_ff;
      blk_c   = blk_ff;
      we_c    = 1'b0;
      rd_c    = 1'b0;
      clr_c   = 1'b0;
      arow_c  = row_ff;
      acol_c  = col_ff;
      wchar_c = ch_ff;
      case (op_ff)
         tcw_pkg::OP_WRITE: begin
            if (!blk_ff) begin
               if (ch_ff == tcw_pkg::CHAR_NEWLINE) begin
                  if (at_last_row) begin
                     blk_c = 1'b1;
                  end else begin
                     row_c = row_ff + RW'(1);
                     col_c = '0;
                  end
               end else begin
                  we_c = 1'b1;
                  if (at_last_col) begin
                     // last cell of the screen keeps the cursor in place
                     if (!at_last_row) begin
                        row_c = row_ff + RW'(1);
                        col_c = '0;
                     end
                  end else begin
                     col_c = col_ff + CW'(1);
                  end
               end
            end
         end
         tcw_pkg::OP_BACK: begin
            // at the origin and not blocked nothing happens
            if (blk_ff || row_ff != '0 || col_ff != '0) begin
               if (col_ff == '0) begin
                  if (row_ff != '0) begin
                     row_c = row_ff - RW'(1);
                     col_c = LAST_COL;
                  end
               end else begin
                  col_c = col_ff - CW'(1);
               end
               blk_c   = 1'b0;
               we_c    = 1'b1;
               arow_c  = row_c;
               acol_c  = col_c;
               wchar_c = tcw_pkg::CHAR_SPACE;
            end
         end
         tcw_pkg::OP_CLEAR: begin
            row_c  = '0;
            col_c  = '0;
            blk_c  = 1'b0;
            clr_c  = 1'b1;
            arow_c = '0;
            acol_c = '0;
         end
         tcw_pkg::OP_MOVE: begin
            if (in_range) begin
               row_c = RW'(trow_ff);
               col_c = CW'(tcol_ff);
               blk_c = 1'b0;
            end
         end
         tcw_pkg::OP_READ: begin
            if (in_range) begin
               rd_c   = 1'b1;
               arow_c = RW'(trow_ff);
               acol_c = CW'(tcol_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // the one multiplier: RAM address in ST_ADDR, cursor position in ST_LIN
   assign mul_row = (state_ff == tcw_pkg::ST_LIN) ? row_ff : arow_ff;
   assign mul_col = (state_ff == tcw_pkg::ST_LIN) ? col_ff : acol_ff;
   assign mul_res = AW'(mul_row) * AW'(COLS) + AW'(mul_col);

   assign ram_we    = ((state_ff == tcw_pkg::ST_ACCESS) && we_ff) ||
                      (state_ff == tcw_pkg::ST_CLEAR);
   assign ram_wdata = (state_ff == tcw_pkg::ST_CLEAR) ? {color_ff, tcw_pkg::CHAR_SPACE}
                                                      : {color_ff, wchar_ff};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ch_in    = ch_ff;
      trow_in  = trow_ff;
      tcol_in  = tcol_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      blk_in   = blk_ff;
      color_in = csr_we ? csr_wdata : color_ff;
      we_in    = we_ff;
      rd_in    = rd_ff;
      clr_in   = clr_ff;
      wchar_in = wchar_ff;
      arow_in  = arow_ff;
      acol_in  = acol_ff;
      addr_in  = addr_ff;
      lin_in   = lin_ff;
      cchar_in = cchar_ff;
      cattr_in = cattr_ff;
      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               ch_in    = req_char_code;
               trow_in  = req_target_row;
               tcol_in  = req_target_col;
               state_in = tcw_pkg::ST_CALC;
            end
         end
         tcw_pkg::ST_CALC: begin
            row_in   = row_c;
            col_in   = col_c;
            blk_in   = blk_c;
            we_in    = we_c;
            rd_in    = rd_c;
            clr_in   = clr_c;
            wchar_in = wchar_c;
            arow_in  = arow_c;
            acol_in  = acol_c;
            state_in = tcw_pkg::ST_ADDR;
         end
         tcw_pkg::ST_ADDR: begin
            addr_in  = mul_res;
            state_in = clr_ff ? tcw_pkg::ST_CLEAR : tcw_pkg::ST_ACCESS;
         end
         tcw_pkg::ST_ACCESS: begin
            state_in = tcw_pkg::ST_LIN;
         end
         tcw_pkg::ST_CLEAR: begin
            if (addr_ff == LAST_ADR) begin
               state_in = tcw_pkg::ST_LIN;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         tcw_pkg::ST_LIN: begin
            lin_in   = mul_res;
            cchar_in = rd_ff ? ram_rdata[7:0]  : 8'd0;
            cattr_in = rd_ff ? ram_rdata[15:8] : 8'd0;
            state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_DONE: begin
            state_in = tcw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         blk_ff   <= 1'b0;
         color_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         blk_ff   <= blk_in;
         color_ff <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      ch_ff    <= ch_in;
      trow_ff  <= trow_in;
      tcol_ff  <= tcol_in;
      we_ff    <= we_in;
      rd_ff    <= rd_in;
      clr_ff   <= clr_in;
      wchar_ff <= wchar_in;
      arow_ff  <= arow_in;
      acol_ff  <= acol_in;
      addr_ff  <= addr_in;
      lin_ff   <= lin_in;
      cchar_ff <= cchar_in;
      cattr_ff <= cattr_in;
   end

   tcw_ram #(
      .WIDTH(tcw_pkg::CELL_W),
      .DEPTH(NCELLS)
   ) u_cells (
      .clock(clock),
      .we   (ram_we),
      .addr (addr_ff),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign rsp_valid          = (state_ff == tcw_pkg::ST_DONE);
   assign rsp_cursor_row     = 5'(row_ff);
   assign rsp_cursor_col     = 7'(col_ff);
   assign rsp_cursor_linear  = 11'(lin_ff);
   assign rsp_cell_char      = cchar_ff;
   assign rsp_cell_attr      = cattr_ff;
   assign rsp_writes_blocked = blk_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLS))
      else $error("cursor outside the screen");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted command not held busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   a_ram_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == tcw_pkg::ST_ACCESS) || (state_ff == tcw_pkg::ST_CLEAR))
      else $error("cell write outside access or clear");

   a_clear_homes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_CLEAR) |-> row_ff == '0 && col_ff == '0 && !blk_ff)
      else $error("cursor not homed during clear");

endmodule
`default_nettype wire

// File: sv/tcw_ram.sv
`default_nettype none
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire
